// ===== sv/rrpg_pkg.sv =====
// Shared constants, types and arithmetic helpers for the radial reference point generator.
package rrpg_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int INNER_RADIUS      = 32;
   localparam int COORD_BITS        = 16;

   localparam logic signed [63:0] GAIN_Q16     = 64'sd39797;
   localparam logic [29:0]        TURN_PER_RAD = 30'd683565276;
   localparam int                 FRAC         = 16;

   localparam int VEC_W  = 38;   // vectoring datapath, Q16 pixels
   localparam int ROT_W  = 38;   // rotation datapath, Q16 pixels
   localparam int R_W    = 36;   // radius, unsigned Q16
   localparam int M_W    = 38;   // moved radius, signed Q16
   localparam int Z_W    = 34;   // residual angle
   localparam int NUM_W  = 53;   // dividend of the arc angle division
   localparam int Q_W    = 32;   // kept quotient bits (angle wraps)
   localparam int MR_W   = 25;   // motion_a * radial_step
   localparam int TR_W   = 22;   // translational coordinate
   localparam int FIN_W  = 24;   // unsaturated output coordinate
   localparam int RB     = $clog2(INNER_RADIUS + 1);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int REQ_W  = 48;
   localparam int RSP_W  = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIAL_STEP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ARC_STEP     = 3'd4;

   typedef struct packed {
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [6:0]  block_size;
      logic [15:0] radial_step;
      logic [15:0] arc_step;
   } cfg_type;

   typedef struct packed {
      logic                   trans;
      logic                   zero;
      logic                   neg;
      logic signed [MR_W-1:0] mr;
      logic signed [TR_W-1:0] tr_x;
      logic signed [TR_W-1:0] tr_y;
   } side_type;

   typedef struct packed {
      side_type                side;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic [31:0]             ang;
      logic [NUM_W-1:0]        num;
   } vec_type;

   typedef struct packed {
      side_type         side;
      logic [R_W-1:0]   r;
      logic [31:0]      ang;
      logic [NUM_W-1:0] dvd;
      logic [R_W-1:0]   rem;
      logic [Q_W-1:0]   q;
   } div_type;

   typedef struct packed {
      side_type              side;
      logic signed [M_W-1:0] m;
      logic signed [Z_W-1:0] z;
   } tz_type;

   typedef struct packed {
      side_type                side;
      logic signed [ROT_W-1:0] px;
      logic signed [ROT_W-1:0] py;
      logic signed [Z_W-1:0]   z;
   } rot_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ref_x;
      logic signed [COORD_BITS-1:0] ref_y;
      logic                         outside;
      logic                         translational;
   } out_type;

   function automatic logic [31:0] atan_bam(input int i);
      case (i)
         0:  return 32'h20000000;
         1:  return 32'h12E4051E;
         2:  return 32'h09FB385B;
         3:  return 32'h051111D4;
         4:  return 32'h028B0D43;
         5:  return 32'h0145D7E1;
         6:  return 32'h00A2F61E;
         7:  return 32'h00517C55;
         8:  return 32'h0028BE53;
         9:  return 32'h00145F2F;
         10: return 32'h000A2F98;
         11: return 32'h000517CC;
         12: return 32'h00028BE6;
         13: return 32'h000145F3;
         14: return 32'h0000A2FA;
         15: return 32'h0000517D;
         16: return 32'h000028BE;
         17: return 32'h0000145F;
         18: return 32'h00000A30;
         19: return 32'h00000518;
         20: return 32'h0000028C;
         21: return 32'h00000146;
         22: return 32'h000000A3;
         23: return 32'h00000051;
         default: return 32'h00000000;
      endcase
   endfunction

   // Shift right by FRAC bits, rounding half away from zero.
   function automatic logic signed [63:0] round16(input logic signed [63:0] v);
      logic signed [63:0] a;
      a = v[63] ? -v : v;
      a = (a + 64'sd32768) >>> FRAC;
      return v[63] ? -a : a;
   endfunction

endpackage

// ===== sv/rrpg_front.sv =====
// Front end: accept requests, classify blocks and prepare the vector for the back end.
module rrpg_front (
   input  logic                        clock,
   input  logic                        reset,
   input  rrpg_pkg::cfg_type           cfg,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rrpg_pkg::REQ_W-1:0]  req_tdata,
   input  logic [rrpg_pkg::QCNT_W-1:0] q_count,
   output logic                        push,
   output rrpg_pkg::vec_type           push_item
);

   typedef struct packed {
      logic [16:0]                      bsc;
      logic [16:0]                      bsr;
      logic [5:0]                       pxo;
      logic [5:0]                       pyo;
      logic signed [7:0]                ma;
      logic signed [7:0]                mb;
      logic                             neg;
      logic [23:0]                      mba;
      logic signed [rrpg_pkg::MR_W-1:0] mr;
   } f1_type;

   f1_type            f1_ff, f1_in;
   logic              f1_v_ff;
   rrpg_pkg::vec_type f2_ff, f2_in;
   logic              f2_v_ff;
   logic              accept;

   logic [9:0]        col, row;
   logic signed [7:0] ma, mb;
   logic [7:0]        mb_abs;

   logic [11:0]                       icx, icy;
   logic signed [18:0]                dx0, dx1, dy0, dy1;
   logic [17:0]                       sum_x, sum_y;
   logic signed [rrpg_pkg::VEC_W-1:0] x0, y0, cx, cy;
   logic [53:0]                       num_full;

   function automatic logic corner_near(input logic signed [18:0] dx,
                                        input logic signed [18:0] dy);
      logic [18:0]                  ax, ay;
      logic [2*rrpg_pkg::RB-1:0]    sx, sy;
      logic [2*rrpg_pkg::RB:0]      s;
      ax = dx[18] ? 19'(-dx) : 19'(dx);
      ay = dy[18] ? 19'(-dy) : 19'(dy);
      sx = ax[rrpg_pkg::RB-1:0] * ax[rrpg_pkg::RB-1:0];
      sy = ay[rrpg_pkg::RB-1:0] * ay[rrpg_pkg::RB-1:0];
      s  = {1'b0, sx} + {1'b0, sy};
      return (ax < rrpg_pkg::INNER_RADIUS) && (ay < rrpg_pkg::INNER_RADIUS)
          && (s < rrpg_pkg::INNER_RADIUS * rrpg_pkg::INNER_RADIUS);
   endfunction

   assign req_tready = (32'(q_count) + 32'(f1_v_ff) + 32'(f2_v_ff)) < rrpg_pkg::QDEPTH;
   assign accept     = req_tvalid && req_tready;

   assign col    = req_tdata[9:0];
   assign row    = req_tdata[19:10];
   assign ma     = $signed(req_tdata[39:32]);
   assign mb     = $signed(req_tdata[47:40]);
   assign mb_abs = mb[7] ? 8'(-mb) : 8'(mb);

   always_comb begin
      f1_in.bsc = 17'(cfg.block_size * col);
      f1_in.bsr = 17'(cfg.block_size * row);
      f1_in.pxo = req_tdata[25:20];
      f1_in.pyo = req_tdata[31:26];
      f1_in.ma  = ma;
      f1_in.mb  = mb;
      f1_in.neg = mb[7];
      f1_in.mba = 24'(mb_abs) * 24'(cfg.arc_step);
      f1_in.mr  = rrpg_pkg::MR_W'(ma) * rrpg_pkg::MR_W'($signed({1'b0, cfg.radial_step}));
   end

   always_comb begin
      icx = cfg.frame_width[12:1];
      icy = cfg.frame_height[12:1];
      dx0 = $signed({2'b00, f1_ff.bsc}) - $signed({7'd0, icx});
      dx1 = $signed({2'b00, f1_ff.bsc}) + $signed({12'd0, cfg.block_size})
          - $signed({7'd0, icx});
      dy0 = $signed({2'b00, f1_ff.bsr}) - $signed({7'd0, icy});
      dy1 = $signed({2'b00, f1_ff.bsr}) + $signed({12'd0, cfg.block_size})
          - $signed({7'd0, icy});

      sum_x = 18'(f1_ff.bsc) + 18'(f1_ff.pxo);
      sum_y = 18'(f1_ff.bsr) + 18'(f1_ff.pyo);
      cx = rrpg_pkg::VEC_W'($signed({1'b0, cfg.frame_width})) <<< 15;
      cy = rrpg_pkg::VEC_W'($signed({1'b0, cfg.frame_height})) <<< 15;
      x0 = (rrpg_pkg::VEC_W'($signed({1'b0, sum_x})) <<< 16) - cx;
      y0 = (rrpg_pkg::VEC_W'($signed({1'b0, sum_y})) <<< 16) - cy;
      num_full = 54'(f1_ff.mba) * 54'(rrpg_pkg::TURN_PER_RAD);

      f2_in.side.trans = corner_near(dx0, dy0) || corner_near(dx1, dy0)
                      || corner_near(dx0, dy1) || corner_near(dx1, dy1);
      f2_in.side.zero  = (x0 == '0) && (y0 == '0);
      f2_in.side.neg   = f1_ff.neg;
      f2_in.side.mr    = f1_ff.mr;
      f2_in.side.tr_x  = rrpg_pkg::TR_W'($signed({1'b0, f1_ff.bsc, 2'b00}))
                       + rrpg_pkg::TR_W'(f1_ff.ma)
                       + rrpg_pkg::TR_W'($signed({1'b0, f1_ff.pxo, 2'b00}));
      f2_in.side.tr_y  = rrpg_pkg::TR_W'($signed({1'b0, f1_ff.bsr, 2'b00}))
                       + rrpg_pkg::TR_W'(f1_ff.mb)
                       + rrpg_pkg::TR_W'($signed({1'b0, f1_ff.pyo, 2'b00}));
      f2_in.num = num_full[rrpg_pkg::NUM_W-1:0];
      if (x0 < 0) begin
         f2_in.x   = -x0;
         f2_in.y   = -y0;
         f2_in.ang = 32'h80000000;
      end else begin
         f2_in.x   = x0;
         f2_in.y   = y0;
         f2_in.ang = 32'h00000000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= accept;
         f2_v_ff <= f1_v_ff;
      end
      if (accept) begin
         f1_ff <= f1_in;
      end
      if (f1_v_ff) begin
         f2_ff <= f2_in;
      end
   end

   assign push      = f2_v_ff;
   assign push_item = f2_ff;

endmodule

// ===== sv/rrpg_queue.sv =====
// Short queue between the front end and the back end.
module rrpg_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  rrpg_pkg::vec_type           push_item,
   input  logic                        pop,
   output logic                        not_empty,
   output rrpg_pkg::vec_type           head,
   output logic [rrpg_pkg::QCNT_W-1:0] count
);

   rrpg_pkg::vec_type                 mem_ff [rrpg_pkg::QDEPTH];
   logic [rrpg_pkg::QPTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [rrpg_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                              do_pop;

   assign not_empty = (cnt_ff != '0);
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ff];
   assign count     = cnt_ff;

   always_comb begin
      wr_in  = push ? rrpg_pkg::QPTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? rrpg_pkg::QPTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + rrpg_pkg::QCNT_W'(push) - rrpg_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/rrpg_vector.sv =====
// Vectoring CORDIC pipeline: polar angle and gain-corrected radius of the pixel.
module rrpg_vector (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  rrpg_pkg::vec_type   in_item,
   output logic                out_valid,
   output rrpg_pkg::div_type   out_item
);

   localparam int N = rrpg_pkg::CORDIC_ITERATIONS;

   rrpg_pkg::vec_type vs_ff [N];
   rrpg_pkg::vec_type vs_in [N];
   logic [N-1:0]      v_ff;
   rrpg_pkg::div_type g_ff, g_in;
   logic              gv_ff;
   logic signed [63:0] r64;

   always_comb begin
      rrpg_pkg::vec_type cur;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            cur = in_item;
         end else begin
            cur = vs_ff[i-1];
         end
         vs_in[i] = cur;
         if (cur.y > 0) begin
            vs_in[i].x   = cur.x + (cur.y >>> i);
            vs_in[i].y   = cur.y - (cur.x >>> i);
            vs_in[i].ang = cur.ang + rrpg_pkg::atan_bam(i);
         end else begin
            vs_in[i].x   = cur.x - (cur.y >>> i);
            vs_in[i].y   = cur.y + (cur.x >>> i);
            vs_in[i].ang = cur.ang - rrpg_pkg::atan_bam(i);
         end
      end
   end

   always_comb begin
      r64       = rrpg_pkg::round16(64'(vs_ff[N-1].x) * rrpg_pkg::GAIN_Q16);
      g_in.side = vs_ff[N-1].side;
      g_in.ang  = vs_ff[N-1].ang;
      g_in.r    = (r64 <= 0) ? rrpg_pkg::R_W'(1) : r64[rrpg_pkg::R_W-1:0];
      g_in.dvd  = vs_ff[N-1].num + rrpg_pkg::NUM_W'(g_in.r >> 1);
      g_in.rem  = '0;
      g_in.q    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         gv_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= {v_ff[N-2:0], in_valid};
         gv_ff <= v_ff[N-1];
      end
      if (en) begin
         for (int i = 0; i < N; i++) begin
            vs_ff[i] <= vs_in[i];
         end
         g_ff <= g_in;
      end
   end

   assign out_valid = gv_ff;
   assign out_item  = g_ff;

endmodule

// ===== sv/rrpg_divider.sv =====
// Restoring divider pipeline, one quotient bit per stage: arc length over radius.
module rrpg_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  rrpg_pkg::div_type   in_item,
   output logic                out_valid,
   output rrpg_pkg::div_type   out_item
);

   localparam int N = rrpg_pkg::NUM_W;

   rrpg_pkg::div_type ds_ff [N];
   rrpg_pkg::div_type ds_in [N];
   logic [N-1:0]      v_ff;

   always_comb begin
      rrpg_pkg::div_type  cur;
      logic [rrpg_pkg::R_W:0] tr;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            cur = in_item;
         end else begin
            cur = ds_ff[k-1];
         end
         ds_in[k]     = cur;
         tr           = {cur.rem, cur.dvd[N-1]};
         ds_in[k].dvd = {cur.dvd[N-2:0], 1'b0};
         if (tr >= {1'b0, cur.r}) begin
            ds_in[k].rem = rrpg_pkg::R_W'(tr - {1'b0, cur.r});
            ds_in[k].q   = {cur.q[rrpg_pkg::Q_W-2:0], 1'b1};
         end else begin
            ds_in[k].rem = tr[rrpg_pkg::R_W-1:0];
            ds_in[k].q   = {cur.q[rrpg_pkg::Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[N-2:0], in_valid};
      end
      if (en) begin
         for (int k = 0; k < N; k++) begin
            ds_ff[k] <= ds_in[k];
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_item  = ds_ff[N-1];

endmodule

// ===== sv/rrpg_rotate.sv =====
// Back end tail: target angle and radius, rotation CORDIC, rounding and saturation.
module rrpg_rotate (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  rrpg_pkg::cfg_type   cfg,
   input  logic                in_valid,
   input  rrpg_pkg::div_type   in_item,
   output logic                out_valid,
   output rrpg_pkg::out_type   out_item
);

   localparam int N = rrpg_pkg::CORDIC_ITERATIONS;
   localparam logic signed [rrpg_pkg::Z_W-1:0] QUARTER = rrpg_pkg::Z_W'(64'sd1073741824);
   localparam logic signed [rrpg_pkg::Z_W-1:0] HALF    = rrpg_pkg::Z_W'(64'sd2147483648);
   localparam logic signed [rrpg_pkg::FIN_W-1:0] SAT_HI =
      rrpg_pkg::FIN_W'(2 ** (rrpg_pkg::COORD_BITS - 1) - 1);
   localparam logic signed [rrpg_pkg::FIN_W-1:0] SAT_LO = -SAT_HI - 1;

   rrpg_pkg::tz_type  t_ff, t_in;
   logic              tv_ff;
   rrpg_pkg::rot_type p_ff, p_in;
   logic              pv_ff;
   rrpg_pkg::rot_type rs_ff [N];
   rrpg_pkg::rot_type rs_in [N];
   logic [N-1:0]      v_ff;
   rrpg_pkg::out_type o_ff, o_in;
   logic              ov_ff;

   logic [31:0]                         dt, tot;
   logic signed [rrpg_pkg::ROT_W-1:0]   fx, fy;
   logic signed [rrpg_pkg::FIN_W-1:0]   rx, ry, w4, h4;
   logic signed [63:0]                  cxq, cyq;

   always_comb begin
      dt  = in_item.side.neg ? 32'(-in_item.q) : in_item.q;
      tot = in_item.ang + dt;
      t_in.side = in_item.side;
      t_in.m = rrpg_pkg::M_W'($signed({1'b0, in_item.r})) + rrpg_pkg::M_W'(in_item.side.mr);
      t_in.z = rrpg_pkg::Z_W'($signed(tot));
      if (t_in.z > QUARTER) begin
         t_in.z = t_in.z - HALF;
         t_in.m = -t_in.m;
      end else if (t_in.z < -QUARTER) begin
         t_in.z = t_in.z + HALF;
         t_in.m = -t_in.m;
      end
   end

   always_comb begin
      p_in.side = t_ff.side;
      p_in.px   = rrpg_pkg::ROT_W'(rrpg_pkg::round16(64'(t_ff.m) * rrpg_pkg::GAIN_Q16));
      p_in.py   = '0;
      p_in.z    = t_ff.z;
   end

   always_comb begin
      rrpg_pkg::rot_type cur;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            cur = p_ff;
         end else begin
            cur = rs_ff[i-1];
         end
         rs_in[i] = cur;
         if (cur.z >= 0) begin
            rs_in[i].px = cur.px - (cur.py >>> i);
            rs_in[i].py = cur.py + (cur.px >>> i);
            rs_in[i].z  = cur.z - rrpg_pkg::Z_W'({1'b0, rrpg_pkg::atan_bam(i)});
         end else begin
            rs_in[i].px = cur.px + (cur.py >>> i);
            rs_in[i].py = cur.py - (cur.px >>> i);
            rs_in[i].z  = cur.z + rrpg_pkg::Z_W'({1'b0, rrpg_pkg::atan_bam(i)});
         end
      end
   end

   always_comb begin
      fx  = rs_ff[N-1].side.zero ? '0 : rs_ff[N-1].px;
      fy  = rs_ff[N-1].side.zero ? '0 : rs_ff[N-1].py;
      cxq = 64'($signed({1'b0, cfg.frame_width})) <<< 15;
      cyq = 64'($signed({1'b0, cfg.frame_height})) <<< 15;
      w4  = $signed({{(rrpg_pkg::FIN_W - 15){1'b0}}, cfg.frame_width, 2'b00});
      h4  = $signed({{(rrpg_pkg::FIN_W - 15){1'b0}}, cfg.frame_height, 2'b00});
      if (rs_ff[N-1].side.trans) begin
         rx = rrpg_pkg::FIN_W'(rs_ff[N-1].side.tr_x);
         ry = rrpg_pkg::FIN_W'(rs_ff[N-1].side.tr_y);
      end else begin
         rx = rrpg_pkg::FIN_W'(rrpg_pkg::round16((64'(fx) + cxq) <<< 2));
         ry = rrpg_pkg::FIN_W'(rrpg_pkg::round16((64'(fy) + cyq) <<< 2));
      end
      o_in.outside       = (rx < 0) || (rx >= w4) || (ry < 0) || (ry >= h4);
      o_in.translational = rs_ff[N-1].side.trans;
      if (rx > SAT_HI) begin
         o_in.ref_x = rrpg_pkg::COORD_BITS'(SAT_HI);
      end else if (rx < SAT_LO) begin
         o_in.ref_x = rrpg_pkg::COORD_BITS'(SAT_LO);
      end else begin
         o_in.ref_x = rrpg_pkg::COORD_BITS'(rx);
      end
      if (ry > SAT_HI) begin
         o_in.ref_y = rrpg_pkg::COORD_BITS'(SAT_HI);
      end else if (ry < SAT_LO) begin
         o_in.ref_y = rrpg_pkg::COORD_BITS'(SAT_LO);
      end else begin
         o_in.ref_y = rrpg_pkg::COORD_BITS'(ry);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
         pv_ff <= 1'b0;
         v_ff  <= '0;
         ov_ff <= 1'b0;
      end else if (en) begin
         tv_ff <= in_valid;
         pv_ff <= tv_ff;
         v_ff  <= {v_ff[N-2:0], pv_ff};
         ov_ff <= v_ff[N-1];
      end
      if (en) begin
         t_ff <= t_in;
         p_ff <= p_in;
         for (int i = 0; i < N; i++) begin
            rs_ff[i] <= rs_in[i];
         end
         o_ff <= o_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_item  = o_ff;

endmodule

// ===== sv/radial_reference_point_generator_top.sv =====
// Radial reference point generator: top level with register port and stream channels.
//
// One result leaves for every request, in order, at a sustained rate of one request per
// clock cycle while the result channel is ready. The pipeline depth is set by the 53-stage
// restoring divider that turns arc length into angle, together with the two 16-stage CORDIC
// pipelines. The front end takes requests while a four-entry queue has room; when a result
// waits with rsp_tready low the whole back end holds and the queue fills, after which
// req_tready drops. Registers are written through the csr_ channel, which is always
// ready; write them only while no request is in flight.
module radial_reference_point_generator_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rrpg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rrpg_pkg::CSR_DAT_W-1:0] csr_data,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // block_col[9:0], block_row[19:10], pixel_x[25:20], pixel_y[31:26],
   // motion_a[39:32], motion_b[47:40]
   input  logic [rrpg_pkg::REQ_W-1:0]     req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // ref_x[15:0], ref_y[31:16]
   output logic [rrpg_pkg::RSP_W-1:0]     rsp_tdata,
   // outside[0], translational[1]
   output logic [1:0]                     rsp_tuser
);

   rrpg_pkg::cfg_type cfg_ff, cfg_in;
   logic              en;

   logic                        push, q_not_empty, pop;
   rrpg_pkg::vec_type           push_item, q_head;
   logic [rrpg_pkg::QCNT_W-1:0] q_count;
   logic                        vec_valid, div_valid;
   rrpg_pkg::div_type           vec_item, div_item;
   rrpg_pkg::out_type           out_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rrpg_pkg::CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_data[12:0];
            rrpg_pkg::CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_data[12:0];
            rrpg_pkg::CSR_BLOCK_SIZE:   cfg_in.block_size   = csr_data[6:0];
            rrpg_pkg::CSR_RADIAL_STEP:  cfg_in.radial_step  = csr_data;
            rrpg_pkg::CSR_ARC_STEP:     cfg_in.arc_step     = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= 13'd1024;
         cfg_ff.frame_height <= 13'd1024;
         cfg_ff.block_size   <= 7'd16;
         cfg_ff.radial_step  <= 16'd12452;
         cfg_ff.arc_step     <= 16'd12452;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // hold the back end while a result waits
   assign en  = !rsp_tvalid || rsp_tready;
   assign pop = en && q_not_empty;

   rrpg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_count    (q_count),
      .push       (push),
      .push_item  (push_item)
   );

   rrpg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head      (q_head),
      .count     (q_count)
   );

   rrpg_vector u_vector (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (q_not_empty),
      .in_item   (q_head),
      .out_valid (vec_valid),
      .out_item  (vec_item)
   );

   rrpg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vec_valid),
      .in_item   (vec_item),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   rrpg_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (div_valid),
      .in_item   (div_item),
      .out_valid (rsp_tvalid),
      .out_item  (out_item)
   );

   assign rsp_tdata = {out_item.ref_y, out_item.ref_x};
   assign rsp_tuser = {out_item.translational, out_item.outside};

endmodule
